// ----- sv/clook_pkg.sv -----
`timescale 1ns / 1ps

package clook_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned TrackBits    = 10;
  localparam int unsigned TagBits      = 8;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    kind_e                kind;
    logic [TrackBits-1:0] track;
    logic [TagBits-1:0]   request_tag;
  } req_t;

  typedef struct packed {
    logic                 out_valid;
    logic [TrackBits-1:0] out_track;
    logic [TagBits-1:0]   out_tag;
    status_e              status;
    logic                 is_empty;
    logic                 is_full;
  } res_t;

  typedef struct packed {
    logic [TrackBits-1:0] track;
    logic [TagBits-1:0]   tag;
  } entry_t;

  typedef struct packed {
    logic                 ins;
    logic                 rem;
    logic [TrackBits-1:0] ref_track;
    entry_t               new_entry;
  } cell_ctrl_t;

  // sweep order: tracks below the reference belong to the wrapped group
  function automatic logic key_after(logic [TrackBits-1:0] a, logic [TrackBits-1:0] b,
                                     logic [TrackBits-1:0] r);
    logic ga;
    logic gb;
    ga = (a < r);
    gb = (b < r);
    if (ga != gb) begin
      return ga;
    end
    return a > b;
  endfunction

endpackage

// ----- sv/clook_cell.sv -----
`timescale 1ns / 1ps

module clook_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clook_pkg::cell_ctrl_t ctrl_i,
  input  logic                  occ_i,
  input  logic                  flag_left_i,
  input  clook_pkg::entry_t     left_i,
  input  clook_pkg::entry_t     right_i,
  output clook_pkg::entry_t     entry_o,
  output logic                  flag_o
);

  clook_pkg::entry_t entry_q;
  clook_pkg::entry_t entry_d;

  assign flag_o = occ_i &&
                  clook_pkg::key_after(entry_q.track, ctrl_i.new_entry.track, ctrl_i.ref_track);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (flag_left_i) begin
        entry_d = left_i;
      end else if (flag_o || !occ_i) begin
        entry_d = ctrl_i.new_entry;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ----- sv/clook_disk_request_queue.sv -----
`timescale 1ns / 1ps

// C-LOOK disk request queue.
// Request channel: req_i is taken on a rising edge with start high and busy low.
//   kind KIND_INSERT adds (track, request_tag) in sweep order; KIND_REMOVE pops
//   the front request. busy stays low, so one transaction can be taken per cycle.
// Result channel: res_o is shown for one cycle with done_o high, the cycle after
//   the transaction was taken (throughput 1 per cycle). The receiver
//   cannot stall; a result not taken in that cycle is gone.
// Storage is a row of DEPTH cells. Each cell compares its track with the new one
//   against the front track and, in the same cycle, keeps its entry, takes its
//   left neighbour's, its right neighbour's or the new request.
// A removal on an empty queue reports STATUS_EMPTY, an insert on a full queue
//   STATUS_FULL; neither changes the queue.
// Reset empties the queue at once; no clearing pass is needed since cells past
//   the fill count are never read.

module clook_disk_request_queue #(
  parameter int unsigned DEPTH = clook_pkg::DepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  clook_pkg::req_t req_i,
  output logic            done_o,
  output clook_pkg::res_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]       count_q;
  logic [CntW-1:0]       count_d;
  logic                  done_q;
  clook_pkg::res_t       res_q;
  clook_pkg::res_t       res_d;
  clook_pkg::cell_ctrl_t ctrl;
  clook_pkg::entry_t     entry [DEPTH];
  logic                  flag  [DEPTH];
  logic                  accept;
  logic                  full;
  logic                  empty;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);

  assign ctrl.ins       = accept && (req_i.kind == clook_pkg::KIND_INSERT) && !full;
  assign ctrl.rem       = accept && (req_i.kind == clook_pkg::KIND_REMOVE) && !empty;
  assign ctrl.ref_track = entry[0].track;
  assign ctrl.new_entry = '{track: req_i.track, tag: req_i.request_tag};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              occ;
    logic              flag_left;
    clook_pkg::entry_t left;
    clook_pkg::entry_t right;

    assign occ = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign flag_left = 1'b0;
      assign left      = ctrl.new_entry;
    end else begin : g_mid
      assign flag_left = flag[i-1];
      assign left      = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = entry[i];
    end else begin : g_inner
      assign right = entry[i+1];
    end

    clook_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .flag_left_i (flag_left),
      .left_i      (left),
      .right_i     (right),
      .entry_o     (entry[i]),
      .flag_o      (flag[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_d.out_valid = ctrl.rem;
    res_d.out_track = ctrl.rem ? entry[0].track : '0;
    res_d.out_tag   = ctrl.rem ? entry[0].tag : '0;
    res_d.status    = clook_pkg::STATUS_OK;
    if (accept && (req_i.kind == clook_pkg::KIND_REMOVE) && empty) begin
      res_d.status = clook_pkg::STATUS_EMPTY;
    end else if (accept && (req_i.kind == clook_pkg::KIND_INSERT) && full) begin
      res_d.status = clook_pkg::STATUS_FULL;
    end
    res_d.is_empty  = (count_d == '0);
    res_d.is_full   = (count_d == CntW'(DEPTH));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("result strobe missing after transaction");

  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result strobe without transaction");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.out_valid) |-> (res_o.status == clook_pkg::STATUS_OK))
    else $error("removed request with error status");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> $stable(count_q))
    else $error("fill count moved without transaction");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int Depth     = int'(clook_pkg::DepthDefault);
  localparam int IdleLimit = 2000;
  localparam int RandItems = 400;

  class sweep_queue_checker;
    logic [clook_pkg::TrackBits-1:0] held_track[Depth];
    logic [clook_pkg::TagBits-1:0]   held_tag[Depth];
    int                              fill;
    clook_pkg::res_t                 owed_results[$];
    int unsigned                     failures;
    int unsigned                     mismatches;
    int unsigned                     n_insert;
    int unsigned                     n_remove;
    int unsigned                     n_full_reject;
    int unsigned                     n_empty_reject;
    int unsigned                     n_checked;
    int                              peak_fill;

    // wrapped group (below the pivot) sorts after the upper group
    function bit sweeps_later(logic [clook_pkg::TrackBits-1:0] a,
                              logic [clook_pkg::TrackBits-1:0] b,
                              logic [clook_pkg::TrackBits-1:0] pivot);
      if ((a < pivot) != (b < pivot)) begin
        return a < pivot;
      end
      return a > b;
    endfunction

    function void note_request(clook_pkg::req_t rq);
      clook_pkg::res_t exp_res;
      int              pos;
      bit              found;
      exp_res        = '0;
      exp_res.status = clook_pkg::STATUS_OK;
      if (rq.kind == clook_pkg::KIND_REMOVE) begin
        n_remove++;
        if (fill == 0) begin
          exp_res.status = clook_pkg::STATUS_EMPTY;
          n_empty_reject++;
        end else begin
          exp_res.out_valid = 1'b1;
          exp_res.out_track = held_track[0];
          exp_res.out_tag   = held_tag[0];
          for (int i = 1; i < fill; i++) begin
            held_track[i-1] = held_track[i];
            held_tag[i-1]   = held_tag[i];
          end
          fill--;
        end
      end else begin
        n_insert++;
        if (fill >= Depth) begin
          exp_res.status = clook_pkg::STATUS_FULL;
          n_full_reject++;
        end else begin
          pos   = fill;
          found = 1'b0;
          for (int i = 1; i < fill; i++) begin
            if (!found && sweeps_later(held_track[i], rq.track, held_track[0])) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (int i = fill; i > pos; i--) begin
            held_track[i] = held_track[i-1];
            held_tag[i]   = held_tag[i-1];
          end
          held_track[pos] = rq.track;
          held_tag[pos]   = rq.request_tag;
          fill++;
          if (fill > peak_fill) peak_fill = fill;
        end
      end
      exp_res.is_empty = (fill == 0);
      exp_res.is_full  = (fill == Depth);
      owed_results.push_back(exp_res);
    endfunction

    function void check_result(clook_pkg::res_t act);
      clook_pkg::res_t exp_res;
      if (owed_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: unexpected result %h at %0t", act, $realtime);
        end
        return;
      end
      exp_res = owed_results.pop_front();
      n_checked++;
      if (act.out_valid !== exp_res.out_valid || act.out_track !== exp_res.out_track ||
          act.out_tag !== exp_res.out_tag || act.status !== exp_res.status ||
          act.is_empty !== exp_res.is_empty || act.is_full !== exp_res.is_full) begin
        failures++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  exp valid=%0d track=%0d tag=%0d status=%0d empty=%0d full=%0d",
                   exp_res.out_valid, exp_res.out_track, exp_res.out_tag,
                   exp_res.status, exp_res.is_empty, exp_res.is_full);
          $display("  got valid=%0d track=%0d tag=%0d status=%0d empty=%0d full=%0d",
                   act.out_valid, act.out_track, act.out_tag,
                   act.status, act.is_empty, act.is_full);
        end
      end
    endfunction

    function int owed_count();
      return owed_results.size();
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  clook_pkg::req_t req_i;
  logic            done_o;
  clook_pkg::res_t res_o;

  sweep_queue_checker sb = new;
  int                 burst_left;
  int                 idle_cycles;

  clook_disk_request_queue #(
    .DEPTH(Depth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_request(req_i);
      if (done_o) sb.check_result(res_o);
      if ((start && !busy) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("ERROR: no transaction for %0d cycles", IdleLimit);
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  task automatic hold_off(input int cycles);
    @(negedge clk_i);
    start <= 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  task automatic issue(input clook_pkg::kind_e k,
                       input logic [clook_pkg::TrackBits-1:0] trk,
                       input logic [clook_pkg::TagBits-1:0] tg);
    clook_pkg::req_t rq;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
    rq.kind        = k;
    rq.track       = trk;
    rq.request_tag = tg;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.owed_count() != 0) @(posedge clk_i);
  endtask

  function automatic logic [clook_pkg::TrackBits-1:0] rand_track();
    return clook_pkg::TrackBits'($urandom_range(0, 1023));
  endfunction

  function automatic logic [clook_pkg::TagBits-1:0] rand_tag();
    return clook_pkg::TagBits'($urandom_range(0, 255));
  endfunction

  function automatic logic [clook_pkg::TrackBits-1:0] pick_track();
    logic [clook_pkg::TrackBits-1:0] edge_vals[5] = '{10'd0, 10'd1, 10'd511, 10'd512, 10'd1023};
    case ($urandom_range(0, 3))
      2:       return edge_vals[$urandom_range(0, 4)];
      3:       return (sb.fill > 0) ? sb.held_track[0] : rand_track();
      default: return rand_track();
    endcase
  endfunction

  initial begin
    int ins_pct;
    int seg_len;
    int sent;
    bit paused;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    burst_left  = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty removal, extremes, equal-to-front, wrap, fill to full
    issue(clook_pkg::KIND_REMOVE, 10'd0, 8'd0);
    issue(clook_pkg::KIND_INSERT, 10'd512, 8'h00);
    issue(clook_pkg::KIND_INSERT, 10'd1023, 8'hff);
    issue(clook_pkg::KIND_INSERT, 10'd0, 8'h01);
    issue(clook_pkg::KIND_INSERT, 10'd512, 8'h02);
    issue(clook_pkg::KIND_INSERT, 10'd700, 8'haa);
    issue(clook_pkg::KIND_INSERT, 10'd100, 8'h55);
    issue(clook_pkg::KIND_REMOVE, 10'h3ff, 8'hff);
    issue(clook_pkg::KIND_REMOVE, 10'h155, 8'h5a);
    for (int i = 0; i < 12; i++) begin
      issue(clook_pkg::KIND_INSERT, (i % 2) ? 10'h2aa ^ i[9:0] : 10'h155 + 10'(i * 67),
            (i % 2) ? 8'ha5 : 8'h5a + 8'(i));
    end
    issue(clook_pkg::KIND_INSERT, 10'd300, 8'h77);
    drain();

    sent   = 0;
    paused = 1'b0;
    while (sent < RandItems) begin
      case ($urandom_range(0, 2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      seg_len = $urandom_range(20, 40);
      for (int i = 0; i < seg_len; i++) begin
        if ($urandom_range(1, 100) <= ins_pct) begin
          issue(clook_pkg::KIND_INSERT, pick_track(), rand_tag());
        end else begin
          issue(clook_pkg::KIND_REMOVE, rand_track(), rand_tag());
        end
        sent++;
      end
      if (!paused || $urandom_range(0, 3) == 0) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.owed_count() != 0) begin
      $display("ERROR: %0d results never arrived", sb.owed_count());
      sb.failures++;
    end
    $display("Ran %0d inserts and %0d removals, %0d refused when full, %0d on empty;",
             sb.n_insert, sb.n_remove, sb.n_full_reject, sb.n_empty_reject);
    $display("checked %0d results, peak occupancy %0d of %0d, %0d mismatches.",
             sb.n_checked, sb.peak_fill, Depth, sb.mismatches);
    if (sb.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
